[rtl/core/ncl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest crystal lookup package
// Shared types, command codes and fixed widths for the crystal lookup block.
// ----------------------------------------------------------------------------
package ncl_pkg;

   // Field widths fixed by the command and result formats.
   localparam int POS_W  = 16;
   localparam int IDX_W  = 6;
   localparam int ID_W   = 6;
   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;

   // Bounds of the event position, Q2.14 plus and minus one.
   localparam logic signed [POS_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [POS_W-1:0] NEG_ONE_Q14 = -16'sd16384;

   // Command codes.
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   // Status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOB = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN
   } ncl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;        // capture the request beat
      logic mem_write;    // store the captured peak
      logic scan_clear;   // restart the scan counter and the running minimum
      logic scan_step;    // read one table entry into the distance pipeline
      logic rsp_load;     // answer a load
      logic rsp_oob;      // answer an out-of-bounds classify
      logic rsp_result;   // answer a finished classify
   } ncl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_classify;
      logic out_of_bounds;
      logic scan_last;
      logic pipe_empty;
   } ncl_stat_type;

endpackage
`default_nettype wire

[rtl/core/ncl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest crystal lookup controller
// Sequences load, bounds check, table scan and pipeline drain for each command.
// ----------------------------------------------------------------------------
module ncl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ncl_pkg::ncl_stat_type stat,
   output ncl_pkg::ncl_cmd_type  cmd
);
   import ncl_pkg::*;

   ncl_state_type state_ff;
   ncl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!stat.is_classify) begin
               cmd.mem_write = 1'b1;
               cmd.rsp_load  = 1'b1;
               state_in      = ST_IDLE;
            end else if (stat.out_of_bounds) begin
               cmd.rsp_oob = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               cmd.rsp_result = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

[rtl/core/ncl_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest crystal lookup datapath
// Peak table memory, squared distance pipeline, running minimum and result
// registers.
// ----------------------------------------------------------------------------
module ncl_datapath #(
   parameter int NUM_PEAKS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_command,
   input  logic [ncl_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [ncl_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [ncl_pkg::POS_W-1:0]   req_pos_y,
   input  ncl_pkg::ncl_cmd_type               cmd,
   output ncl_pkg::ncl_stat_type              stat,
   output logic                               rsp_strobe,
   output logic                               rsp_status,
   output logic [ncl_pkg::ID_W-1:0]           rsp_crystal_id
);
   import ncl_pkg::*;

   localparam int AW = $clog2(NUM_PEAKS);

   // Captured request.
   logic                    cmd_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [POS_W-1:0] ev_x_ff;
   logic signed [POS_W-1:0] ev_y_ff;

   // Peak table, x in the upper half and y in the lower half of each word.
   logic [2*POS_W-1:0]      peak_mem [NUM_PEAKS];
   logic [2*POS_W-1:0]      rd_data_ff;
   logic                    idx_in_range;

   // Scan counter and pipeline stages.
   logic [AW-1:0]           scan_cnt_ff;
   logic                    s1_vld_ff;
   logic [AW-1:0]           s1_id_ff;
   logic signed [POS_W-1:0] rd_x;
   logic signed [POS_W-1:0] rd_y;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [SQ_W-1:0]  prod_x;
   logic signed [SQ_W-1:0]  prod_y;
   logic                    s2_vld_ff;
   logic [AW-1:0]           s2_id_ff;
   logic [SQ_W-1:0]         sq_x_ff;
   logic [SQ_W-1:0]         sq_y_ff;
   logic                    s3_vld_ff;
   logic [AW-1:0]           s3_id_ff;
   logic [SQ_W-1:0]         sum_ff;
   logic [SQ_W-1:0]         sum_in;

   // Running minimum.
   logic                    best_vld_ff;
   logic [SQ_W-1:0]         best_ff;
   logic [AW-1:0]           best_id_ff;

   // Result registers.
   logic                    rsp_strobe_ff;
   logic                    rsp_status_ff;
   logic [ID_W-1:0]         rsp_id_ff;

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_entry_index;
         ev_x_ff <= req_pos_x;
         ev_y_ff <= req_pos_y;
      end
   end

   assign idx_in_range = (int'(idx_ff) < NUM_PEAKS);

   // Table memory: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.mem_write && idx_in_range) begin
         peak_mem[AW'(idx_ff)] <= {ev_x_ff, ev_y_ff};
      end
      rd_data_ff <= peak_mem[scan_cnt_ff];
   end

   // Scan address counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clear) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
   end

   // Differences to the event and their squares.
   assign rd_x   = rd_data_ff[2*POS_W-1:POS_W];
   assign rd_y   = rd_data_ff[POS_W-1:0];
   assign dx     = DIFF_W'(rd_x) - DIFF_W'(ev_x_ff);
   assign dy     = DIFF_W'(rd_y) - DIFF_W'(ev_y_ff);
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;
   assign sum_in = sq_x_ff + sq_y_ff;

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.scan_step;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      s1_id_ff <= scan_cnt_ff;
      s2_id_ff <= s1_id_ff;
      sq_x_ff  <= $unsigned(prod_x);
      sq_y_ff  <= $unsigned(prod_y);
      s3_id_ff <= s2_id_ff;
      sum_ff   <= sum_in;
   end

   // Keep the first strict minimum so the lowest index wins a tie.
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clear) begin
         best_vld_ff <= 1'b0;
      end else if (s3_vld_ff && (!best_vld_ff || sum_ff < best_ff)) begin
         best_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_vld_ff && (!best_vld_ff || sum_ff < best_ff)) begin
         best_ff    <= sum_ff;
         best_id_ff <= s3_id_ff;
      end
   end

   // Result beat, shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load | cmd.rsp_oob | cmd.rsp_result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= cmd.rsp_oob ? STATUS_OOB : STATUS_OK;
      rsp_id_ff     <= cmd.rsp_result ? ID_W'(best_id_ff) : '0;
   end

   // Status to the controller.
   always_comb begin
      stat.is_classify   = (cmd_ff == CMD_CLASSIFY);
      stat.out_of_bounds = (ev_x_ff > ONE_Q14) || (ev_x_ff < NEG_ONE_Q14) ||
                           (ev_y_ff > ONE_Q14) || (ev_y_ff < NEG_ONE_Q14);
      stat.scan_last     = (scan_cnt_ff == AW'(NUM_PEAKS - 1));
      stat.pipe_empty    = !(s1_vld_ff || s2_vld_ff || s3_vld_ff);
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_crystal_id = rsp_id_ff;

endmodule
`default_nettype wire

[rtl/core/nearest_crystal_lookup.sv]
`default_nettype none
// Load and out-of-bounds commands: the start beat is latched and answered from the
// dispatch state through the result registers. Classify: the scan reads one table entry
// per cycle from the single read port of the peak memory, and the result follows the drain.
// busy drops in the cycle the result is shown, so the next start is taken then.
// Synchronous active-high reset returns the controller to idle; the peak table is
// not cleared and must be loaded before classify commands are issued.
// ----------------------------------------------------------------------------
// Nearest crystal lookup
// Classifies an event position to the nearest stored crystal peak by squared
// Euclidean distance, with a load command to fill the peak table.
// ----------------------------------------------------------------------------
module nearest_crystal_lookup #(
   parameter int NUM_PEAKS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [ncl_pkg::IDX_W-1:0]        req_entry_index,
   input  logic signed [ncl_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [ncl_pkg::POS_W-1:0] req_pos_y,
   output logic                             rsp_strobe,
   output logic                             rsp_status,
   output logic [ncl_pkg::ID_W-1:0]         rsp_crystal_id
);
   import ncl_pkg::*;

   ncl_cmd_type  cmd;
   ncl_stat_type stat;

   // Command sequencer.
   ncl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Table, distance pipeline and result registers.
   ncl_datapath #(
      .NUM_PEAKS (NUM_PEAKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_crystal_id  (rsp_crystal_id)
   );

endmodule
`default_nettype wire

[rtl/core/ncl_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest crystal lookup checker
// Port-level timing checks on command acceptance and result beats.
// ----------------------------------------------------------------------------
module ncl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             req_command,
   input wire logic signed [ncl_pkg::POS_W-1:0] req_pos_x,
   input wire logic signed [ncl_pkg::POS_W-1:0] req_pos_y,
   input wire logic                             rsp_strobe,
   input wire logic                             rsp_status,
   input wire logic [ncl_pkg::ID_W-1:0]         rsp_crystal_id
);
   import ncl_pkg::*;

   logic accept;
   logic oob;

   assign accept = start && !busy;
   assign oob    = (req_pos_x > ONE_Q14) || (req_pos_x < NEG_ONE_Q14) ||
                   (req_pos_y > ONE_Q14) || (req_pos_y < NEG_ONE_Q14);

   // An accepted beat makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted command");

   // A result beat only appears once the block has gone idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // A load is acknowledged after the dispatch state with an ok status and id zero.
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_LOAD) |-> ##2
      (rsp_strobe && rsp_status == STATUS_OK && rsp_crystal_id == '0))
      else $error("load acknowledge missing or wrong");

   // An event outside the bounds is rejected after the dispatch state.
   a_oob_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_CLASSIFY && oob) |-> ##2
      (rsp_strobe && rsp_status == STATUS_OOB && rsp_crystal_id == '0))
      else $error("out-of-bounds reject missing or wrong");

   // Result beats never follow each other directly.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

bind nearest_crystal_lookup ncl_checker u_ncl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .req_pos_x       (req_pos_x),
   .req_pos_y       (req_pos_y),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_crystal_id  (rsp_crystal_id)
);
`default_nettype wire
